### rtl/spfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfs_pkg
// Shared constants for the smallest prime factor sieve block and its checker.
// ----------------------------------------------------------------------------
package spfs_pkg;

	localparam int NUM_W       = 20;
	localparam int MAX_N_DEF   = 1048576;
	localparam logic [NUM_W-1:0] LIMIT_RESET = 20'hFFFFF;

	localparam logic REQ_BUILD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_UNBUILT = 2'd2;

endpackage
`default_nettype wire

### rtl/smallest_prime_factor_sieve_query.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_query
// Builds a smallest prime factor table in memory and answers factor queries.
// ----------------------------------------------------------------------------
// One item is handled at a time, against a single-port table of MAX_N entries.
// A build fills the table from 0 to the limit and then runs the sieve, which
// reads and checks table entries in pairs of states (S_RDP/S_CKP and
// S_RDM/S_CKM); its result passes through S_DONE into the output register.
// A query reads the table and divides out each prime factor, counted with
// multiplicity, with a restoring divider that makes one quotient bit per
// cycle, then passes through S_QFIN and S_DONE. Error results go straight
// from S_IDLE to S_DONE. A finished result waits in an output register, and
// the next item is taken as soon as the block is idle.
module smallest_prime_factor_sieve_query #(
	parameter int MAX_N = spfs_pkg::MAX_N_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [19:0] cfg_upper_limit,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [19:0] number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [19:0]      smallest_factor,
	output logic             is_prime,
	output logic [2:0]       distinct_primes,
	output logic [7:0]       divisor_count
);

	localparam int AW      = $clog2(MAX_N);
	localparam int LIM_CAP = (MAX_N - 1 > 1048575) ? 1048575 : MAX_N - 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_INIT = 11'b00000000010,
		S_RDP  = 11'b00000000100,
		S_CKP  = 11'b00000001000,
		S_RDM  = 11'b00000010000,
		S_CKM  = 11'b00000100000,
		S_QRD  = 11'b00001000000,
		S_QCK  = 11'b00010000000,
		S_QDIV = 11'b00100000000,
		S_QFIN = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t      state_q;
	logic [19:0] upper_q;
	logic        built_q;
	logic [19:0] lim;

	logic [19:0] mem [MAX_N];
	logic [19:0] rdata_q;
	logic [AW-1:0] addr;
	logic        mem_re;
	logic        mem_we;
	logic [19:0] wdata;

	logic [19:0] i_q;
	logic [10:0] p_q;
	logic [21:0] psq;
	logic [20:0] m_q;

	logic [19:0] n_q, x_q, f_q, prev_q, sf_q;
	logic [20:0] rem_q, trial;
	logic [4:0]  dcnt_q, expo_q, distinct_q;
	logic [7:0]  divs_q, divs_sat;
	logic [12:0] dprod;
	logic        first_q;

	logic [1:0]  res_status_q, status_q;
	logic [19:0] res_sf_q, sf_out_q;
	logic        res_prime_q, prime_out_q;
	logic [2:0]  res_dist_q, dist_out_q;
	logic [7:0]  res_divs_q, divs_out_q;
	logic        out_valid_q;

	assign lim       = (upper_q > 20'(LIM_CAP)) ? 20'(LIM_CAP) : upper_q;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign psq       = {11'd0, p_q} * {11'd0, p_q};
	assign trial     = {rem_q[19:0], x_q[19]};
	assign dprod     = {5'd0, divs_q} * {8'd0, expo_q + 5'd1};
	assign divs_sat  = (dprod > 13'd255) ? 8'd255 : dprod[7:0];

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign smallest_factor = sf_out_q;
	assign is_prime        = prime_out_q;
	assign distinct_primes = dist_out_q;
	assign divisor_count   = divs_out_q;

	always_comb begin
		addr   = '0;
		mem_re = 1'b0;
		mem_we = 1'b0;
		wdata  = i_q;
		case (state_q)
			S_INIT: begin
				addr   = AW'(i_q);
				mem_we = 1'b1;
				// Even numbers from four on start out marked with two.
				wdata  = (i_q >= 20'd4 && !i_q[0]) ? 20'd2 : i_q;
			end
			S_RDP: begin
				addr   = AW'(p_q);
				mem_re = 1'b1;
			end
			S_RDM: begin
				addr   = AW'(m_q);
				mem_re = 1'b1;
			end
			S_CKM: begin
				addr   = AW'(m_q);
				mem_we = (rdata_q == m_q[19:0]);
				wdata  = {9'd0, p_q};
			end
			S_QRD: begin
				addr   = AW'(x_q);
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			upper_q     <= spfs_pkg::LIMIT_RESET;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				upper_q <= cfg_upper_limit;
				built_q <= 1'b0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_status_q <= spfs_pkg::STAT_OK;
						res_sf_q     <= '0;
						res_prime_q  <= 1'b0;
						res_dist_q   <= '0;
						res_divs_q   <= '0;
						n_q          <= number;
						x_q          <= number;
						prev_q       <= '0;
						distinct_q   <= '0;
						divs_q       <= 8'd1;
						expo_q       <= '0;
						first_q      <= 1'b1;
						i_q          <= '0;
						if (req_type == spfs_pkg::REQ_BUILD) begin
							state_q <= S_INIT;
						end else if (!built_q) begin
							res_status_q <= spfs_pkg::STAT_UNBUILT;
							state_q      <= S_DONE;
						end else if (number == 20'd0 || number > lim) begin
							res_status_q <= spfs_pkg::STAT_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_QRD;
						end
					end
				end
				S_INIT: begin
					if (i_q == lim) begin
						p_q     <= 11'd3;
						state_q <= S_RDP;
					end else begin
						i_q <= i_q + 20'd1;
					end
				end
				S_RDP: begin
					if (psq > {2'b00, lim}) begin
						built_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CKP;
					end
				end
				S_CKP: begin
					if (rdata_q == {9'd0, p_q}) begin
						m_q     <= psq[20:0];
						state_q <= S_RDM;
					end else begin
						p_q     <= p_q + 11'd2;
						state_q <= S_RDP;
					end
				end
				S_RDM: begin
					if (m_q > {1'b0, lim}) begin
						p_q     <= p_q + 11'd2;
						state_q <= S_RDP;
					end else begin
						state_q <= S_CKM;
					end
				end
				S_CKM: begin
					m_q     <= m_q + {10'd0, p_q};
					state_q <= S_RDM;
				end
				S_QRD: begin
					state_q <= S_QCK;
				end
				S_QCK: begin
					if (first_q) begin
						sf_q    <= rdata_q;
						first_q <= 1'b0;
					end
					if (x_q <= 20'd1 || rdata_q < 20'd2) begin
						state_q <= S_QFIN;
					end else begin
						if (rdata_q != prev_q) begin
							if (expo_q != 5'd0) begin
								divs_q <= divs_sat;
							end
							distinct_q <= distinct_q + 5'd1;
							prev_q     <= rdata_q;
							expo_q     <= 5'd1;
						end else begin
							expo_q <= expo_q + 5'd1;
						end
						f_q     <= rdata_q;
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_QDIV;
					end
				end
				S_QDIV: begin
					// Restoring division, one quotient bit per cycle into x_q.
					if (trial >= {1'b0, f_q}) begin
						rem_q <= trial - {1'b0, f_q};
						x_q   <= {x_q[18:0], 1'b1};
					end else begin
						rem_q <= trial;
						x_q   <= {x_q[18:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(spfs_pkg::NUM_W - 1)) begin
						state_q <= S_QRD;
					end
				end
				S_QFIN: begin
					res_sf_q    <= sf_q;
					res_prime_q <= (n_q > 20'd1) && (sf_q == n_q);
					res_dist_q  <= (distinct_q > 5'd7) ? 3'd7 : distinct_q[2:0];
					res_divs_q  <= (expo_q != 5'd0) ? divs_sat : divs_q;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						sf_out_q    <= res_sf_q;
						prime_out_q <= res_prime_q;
						dist_out_q  <= res_dist_q;
						divs_out_q  <= res_divs_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/spfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfs_checker
// Port-level checks on the results of the smallest prime factor sieve block.
// ----------------------------------------------------------------------------
module spfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [19:0] smallest_factor,
	input wire logic        is_prime,
	input wire logic [2:0]  distinct_primes,
	input wire logic [7:0]  divisor_count
);

	// A stalled result item must stay offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// Error results carry nothing but the status.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != spfs_pkg::STAT_OK |->
		smallest_factor == 20'd0 && !is_prime && distinct_primes == 3'd0 &&
		divisor_count == 8'd0)
		else $error("error result carries data");

	// A prime has exactly one prime factor, itself, and two divisors.
	a_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_prime |->
		status == spfs_pkg::STAT_OK && distinct_primes == 3'd1 && divisor_count == 8'd2)
		else $error("prime result inconsistent");

endmodule

bind smallest_prime_factor_sieve_query spfs_checker u_spfs_checker (.*);
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the smallest prime factor sieve. It walks through
// several table limits, builds the table and factors numbers. Every result is
// checked against a sieve kept inside the bench.
// ----------------------------------------------------------------------------
import spfs_pkg::*;

typedef struct packed {
	logic [1:0]  status;
	logic [19:0] spf;
	logic        prime;
	logic [2:0]  distinct;
	logic [7:0]  divisors;
} factor_result_t;

class factor_scoreboard;
	int unsigned spf_tab[];
	bit table_ready;
	logic [19:0] limit;
	factor_result_t expected_q[$];
	int fails;

	function new();
		spf_tab = new[MAX_N_DEF];
		limit = LIMIT_RESET;
		table_ready = 0;
		fails = 0;
	endfunction

	function void set_limit(logic [19:0] v);
		limit = v;
		table_ready = 0;
	endfunction

	function void run_sieve();
		int unsigned lim;
		longint unsigned p, m;
		lim = limit;
		spf_tab[0] = 0;
		for (int unsigned i = 1; i <= lim; i++) spf_tab[i] = i;
		for (int unsigned i = 4; i <= lim; i += 2) spf_tab[i] = 2;
		for (p = 3; p * p <= lim; p++) begin
			if (spf_tab[p] != p) continue;
			for (m = p * p; m <= lim; m += p)
				if (spf_tab[m] == m) spf_tab[m] = p;
		end
		table_ready = 1;
	endfunction

	// Works out the result of one accepted item and queues it.
	function void note_item(logic req, logic [19:0] num);
		factor_result_t r;
		int unsigned x, f, last, cnt, divs, expo;
		r = '0;
		if (req == REQ_BUILD) begin
			run_sieve();
			r.status = STAT_OK;
		end else if (!table_ready) begin
			r.status = STAT_UNBUILT;
		end else if (num == 0 || num > limit) begin
			r.status = STAT_RANGE;
		end else begin
			x = num;
			last = 0;
			cnt = 0;
			divs = 1;
			expo = 0;
			while (x > 1) begin
				f = spf_tab[x];
				if (f < 2) break;
				if (f != last) begin
					if (expo != 0) divs *= expo + 1;
					if (divs > 255) divs = 255;
					cnt++;
					last = f;
					expo = 0;
				end
				expo++;
				x /= f;
			end
			if (expo != 0) divs *= expo + 1;
			if (divs > 255) divs = 255;
			if (cnt > 7) cnt = 7;
			r.status = STAT_OK;
			r.spf = 20'(spf_tab[num]);
			r.prime = (num > 1 && spf_tab[num] == num);
			r.distinct = 3'(cnt);
			r.divisors = 8'(divs);
		end
		expected_q = {expected_q, r};
	endfunction

	function void check_result(factor_result_t got);
		factor_result_t want;
		if (expected_q.size() == 0) begin
			fails++;
			if (fails <= 10) $display("unexpected result %p", got);
			return;
		end
		want = expected_q.pop_front();
		if (got.status !== want.status || got.spf !== want.spf ||
				got.prime !== want.prime || got.distinct !== want.distinct ||
				got.divisors !== want.divisors) begin
			fails++;
			if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
		end
	endfunction
endclass

module tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [19:0] cfg_upper_limit = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        req_type = REQ_QUERY;
	logic [19:0] number = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [19:0] smallest_factor;
	logic        is_prime;
	logic [2:0]  distinct_primes;
	logic [7:0]  divisor_count;

	factor_scoreboard sb = new();
	bit idling = 1;
	int unsigned cur_lim = LIMIT_RESET;
	logic [19:0] lims[10] = '{20'hFFFFF, 0, 1, 2, 3, 30, 997, 4096, 65535, 0};

	smallest_prime_factor_sieve_query dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_upper_limit(cfg_upper_limit),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .number(number),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.smallest_factor(smallest_factor), .is_prime(is_prime),
		.distinct_primes(distinct_primes), .divisor_count(divisor_count)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int gap_len();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status, smallest_factor, is_prime, distinct_primes, divisor_count});
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				out_ready = 1;
				if (idling && $urandom_range(0, 3) == 0) stall = gap_len();
			end
		end
	end

	task automatic send_item(logic req, logic [19:0] num);
		int g;
		g = idling ? gap_len() : 0;
		repeat (g) @(negedge clk);
		@(negedge clk);
		in_valid = 1;
		req_type = req;
		number = num;
		do @(posedge clk); while (!in_ready);
		sb.note_item(req, num);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic wait_idle();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [19:0] v);
		@(negedge clk);
		cfg_valid = 1;
		cfg_upper_limit = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_limit(v);
		cur_lim = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic logic [19:0] pick_query();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k == 0) return 20'($urandom());
		if (k == 1) return '0;
		if (k == 2) return 20'(cur_lim + 1);
		if (cur_lim == 0) return 20'($urandom());
		return 20'($urandom_range(1, cur_lim));
	endfunction

	initial begin
		logic [19:0] corner[] = '{0, 1, 2, 3, 4, 97, 1024, 720, 55440, 65535, 1048575};
		lims[9] = 20'($urandom_range(2, 5000));
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Queries before any build must report an unbuilt table.
		send_item(REQ_QUERY, 1);
		send_item(REQ_QUERY, 0);
		foreach (lims[ph]) begin
			wait_idle();
			write_limit(lims[ph]);
			idling = (ph % 3 != 2);
			send_item(REQ_QUERY, 1);
			// A full-range build would take too long, so it is skipped.
			if (lims[ph] != 20'hFFFFF) send_item(REQ_BUILD, 20'($urandom()));
			foreach (corner[i]) send_item(REQ_QUERY, corner[i]);
			send_item(REQ_QUERY, cur_lim[19:0]);
			send_item(REQ_QUERY, 20'(cur_lim + 1));
			for (int n = 0; n < 200; n++) begin
				if (lims[ph] <= 5000 && $urandom_range(0, 19) == 0)
					send_item(REQ_BUILD, 20'($urandom()));
				else
					send_item(REQ_QUERY, pick_query());
			end
		end
		wait_idle();
		if (sb.fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb NOT OK");
		$finish;
	end
endmodule
